FILE: sv/kcf_pkg.sv
// Shared types and constants of the knock correction pipeline.
`timescale 1ns / 1ps

package kcf_pkg;

  // Field widths fixed by the item format
  localparam int RPM_W    = 14;
  localparam int TEMP_W   = 16;
  localparam int LIM_W    = 16;
  localparam int IDX_W    = 4;
  localparam int CELL_W   = 8;
  localparam int CORR_W   = 16;
  localparam int MV_W     = 16;
  localparam int T_W      = 17;
  localparam int TPROD_W  = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Temperature term: product is in 1/64 degree steps, 1.0 in Q1.16
  localparam int            TEMP_FRAC = 6;
  localparam logic [T_W-1:0] T_ONE    = 17'h10000;

  // Register reset values
  localparam logic [7:0]        KNOCK_THRESHOLD_RST = 8'd1;
  localparam logic [TEMP_W-1:0] TEMP_BASE_RST       = 16'hF880;  // -1920
  localparam logic [15:0]       TEMP_GAIN_RST       = 16'd655;
  localparam logic [RPM_W-1:0]  AXIS_START_RST      = 14'd500;

  typedef enum logic {
    OP_COMPUTE = 1'b0,
    OP_LOAD    = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KNOCK_THRESHOLD = 2'd0,
    REG_TEMP_BASE       = 2'd1,
    REG_TEMP_GAIN       = 2'd2,
    REG_AXIS_START      = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]               knock_threshold;
    logic signed [TEMP_W-1:0] temp_base;
    logic [15:0]              temp_gain;
    logic [RPM_W-1:0]         axis_start;
  } cfg_t;

  // Split stage -> fetch stage
  typedef struct packed {
    op_e                op;
    logic               active;
    logic               tzero;
    logic [TPROD_W-1:0] tprod;
    logic               below;
    logic               above;
    logic [RPM_W-1:0]   quot;
    logic [RPM_W-1:0]   offv;
    logic [LIM_W-1:0]   lim;
    logic [IDX_W-1:0]   cell_index;
    logic [CELL_W-1:0]  cell_value;
  } split_beat_t;

  // Fetch stage -> interpolation
  typedef struct packed {
    logic              active;
    logic [RPM_W-1:0]  frac;
    logic [T_W-1:0]    t;
    logic [LIM_W-1:0]  lim;
    logic [CELL_W-1:0] c0;
    logic [CELL_W-1:0] c1;
  } fetch_beat_t;

  // Interpolation -> output stage
  typedef struct packed {
    logic             active;
    logic [T_W-1:0]   t;
    logic [LIM_W-1:0] lim;
    logic [MV_W-1:0]  mv;
  } interp_beat_t;

endpackage

FILE: sv/kcf_in_if.sv
// Input channel: valid/ready with one compute or load item per beat.
`timescale 1ns / 1ps

interface kcf_in_if import kcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        enable_byte;
  logic [7:0]        knock_byte;
  logic [TEMP_W-1:0] coolant_temp;
  logic [RPM_W-1:0]  engine_rpm;
  logic [LIM_W-1:0]  correction_limit;
  logic [IDX_W-1:0]  cell_index;
  logic [CELL_W-1:0] cell_value;

  modport source (
    output valid, operation, enable_byte, knock_byte, coolant_temp, engine_rpm,
           correction_limit, cell_index, cell_value,
    input  ready
  );
  modport sink (
    input  valid, operation, enable_byte, knock_byte, coolant_temp, engine_rpm,
           correction_limit, cell_index, cell_value,
    output ready
  );
endinterface

FILE: sv/kcf_out_if.sv
// Output channel: valid/ready with one correction result per beat.
`timescale 1ns / 1ps

interface kcf_out_if import kcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CORR_W-1:0] correction;
  logic              active;

  modport source (output valid, correction, active, input ready);
  modport sink (input valid, correction, active, output ready);
endinterface

FILE: sv/kcf_split.sv
// Gate check, temperature product and rpm-to-cell split (two stages).
`timescale 1ns / 1ps

module kcf_split import kcf_pkg::*; #(
  parameter int MAP_POINTS = 11,
  parameter int AXIS_STEP  = 500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  kcf_in_if.sink      in_i,
  output logic        valid_o,
  input  logic        ready_i,
  output split_beat_t beat_o
);

  // Exact floor(off / AXIS_STEP) by a rounded-up reciprocal
  localparam int I_SHIFT = 26;
  localparam int RECIP_W = I_SHIFT + 1;
  localparam int QP_W    = RPM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_I =
    RECIP_W'((2**I_SHIFT + AXIS_STEP - 1) / AXIS_STEP);
  localparam int SPAN = (MAP_POINTS - 1) * AXIS_STEP;

  logic               s1_v_q;
  op_e                s1_op_q;
  logic               s1_active_q;
  logic               s1_dpos_q;
  logic [TEMP_W-1:0]  s1_dmag_q;
  logic               s1_below_q;
  logic [RPM_W-1:0]   s1_offv_q;
  logic [LIM_W-1:0]   s1_lim_q;
  logic [IDX_W-1:0]   s1_idx_q;
  logic [CELL_W-1:0]  s1_val_q;

  logic               s2_v_q;
  split_beat_t        s2_q;
  split_beat_t        s2_d;

  logic               s1_ready;
  logic               s2_ready;
  logic signed [TEMP_W:0] diff;
  logic [QP_W-1:0]    qprod;

  assign s2_ready   = !s2_v_q || ready_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign valid_o    = s2_v_q;
  assign beat_o     = s2_q;

  // Temperature offset, 17 bits signed
  assign diff = $signed({in_i.coolant_temp[TEMP_W-1], in_i.coolant_temp})
              - $signed({cfg_i.temp_base[TEMP_W-1], cfg_i.temp_base});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= in_i.valid;
      if (s2_ready) s2_v_q <= s1_v_q;
    end
  end

  // Stage 1: gate, offsets
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_op_q     <= op_e'(in_i.operation);
      s1_active_q <= (in_i.enable_byte == 8'd1) &&
                     (in_i.knock_byte > cfg_i.knock_threshold);
      s1_dpos_q   <= !diff[TEMP_W] && (diff != '0);
      s1_dmag_q   <= diff[TEMP_W-1:0];
      s1_below_q  <= in_i.engine_rpm <= cfg_i.axis_start;
      s1_offv_q   <= in_i.engine_rpm - cfg_i.axis_start;
      s1_lim_q    <= in_i.correction_limit;
      s1_idx_q    <= in_i.cell_index;
      s1_val_q    <= in_i.cell_value;
    end
  end

  // Stage 2: quotient by the axis step, range flags, temperature product
  assign qprod = QP_W'(s1_offv_q) * QP_W'(RECIP_I);

  always_comb begin
    s2_d.op         = s1_op_q;
    s2_d.active     = s1_active_q;
    s2_d.tzero      = !s1_dpos_q;
    s2_d.tprod      = TPROD_W'(s1_dmag_q) * TPROD_W'(cfg_i.temp_gain);
    s2_d.below      = s1_below_q;
    s2_d.above      = !s1_below_q && (32'(s1_offv_q) >= SPAN);
    s2_d.quot       = qprod[I_SHIFT +: RPM_W];
    s2_d.offv       = s1_offv_q;
    s2_d.lim        = s1_lim_q;
    s2_d.cell_index = s1_idx_q;
    s2_d.cell_value = s1_val_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) s2_q <= s2_d;
  end

endmodule

FILE: sv/kcf_fetch.sv
// Map cell memory: load writes, two-port cell read, step fraction and clamp.
`timescale 1ns / 1ps

module kcf_fetch import kcf_pkg::*; #(
  parameter int MAP_POINTS = 11,
  parameter int AXIS_STEP  = 500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  split_beat_t beat_i,
  output logic        valid_o,
  input  logic        ready_i,
  output fetch_beat_t beat_o
);

  localparam int ADDR_W = $clog2(MAP_POINTS);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(MAP_POINTS - 1);

  logic [CELL_W-1:0] mem [MAP_POINTS];
  logic [CELL_W-1:0] rd0_q;
  logic [CELL_W-1:0] rd1_q;

  logic              v_q;
  logic              active_q;
  logic [RPM_W-1:0]  frac_q;
  logic [T_W-1:0]    t_q;
  logic [LIM_W-1:0]  lim_q;

  logic              fire;
  logic              is_load;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] a0;
  logic [ADDR_W-1:0] a1;
  logic [31:0]       step_base;
  logic [31:0]       frac_full;
  logic [RPM_W-1:0]  frac;
  logic [TPROD_W-TEMP_FRAC-1:0] tshift;
  logic [T_W-1:0]    t;

  assign ready_o = !v_q || ready_i;
  assign fire    = valid_i && ready_o;
  assign is_load = beat_i.op == OP_LOAD;
  assign idx     = beat_i.quot[ADDR_W-1:0];

  // Cell addresses; clamped ends use one cell with zero fraction
  always_comb begin
    if (beat_i.below) begin
      a0 = '0;
      a1 = '0;
    end else if (beat_i.above) begin
      a0 = LAST;
      a1 = LAST;
    end else begin
      a0 = idx;
      a1 = idx + 1'b1;
    end
  end

  // Offset within the step
  assign step_base = 32'(idx) * 32'(AXIS_STEP);
  assign frac_full = 32'(beat_i.offv) - step_base;
  assign frac      = (beat_i.below || beat_i.above) ? '0 : frac_full[RPM_W-1:0];

  // Temperature term clamped to [0, 1.0]
  assign tshift = beat_i.tprod[TPROD_W-1:TEMP_FRAC];
  always_comb begin
    if (beat_i.tzero) begin
      t = '0;
    end else if (tshift > (TPROD_W-TEMP_FRAC)'(T_ONE)) begin
      t = T_ONE;
    end else begin
      t = tshift[T_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i && !is_load;
    end
  end

  // Cell memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (fire && is_load && (32'(beat_i.cell_index) < MAP_POINTS)) begin
      mem[ADDR_W'(beat_i.cell_index)] <= beat_i.cell_value;
    end
    if (fire && !is_load) begin
      rd0_q <= mem[a0];
      rd1_q <= mem[a1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !is_load) begin
      active_q <= beat_i.active;
      frac_q   <= frac;
      t_q      <= t;
      lim_q    <= beat_i.lim;
    end
  end

  assign valid_o       = v_q;
  assign beat_o.active = active_q;
  assign beat_o.frac   = frac_q;
  assign beat_o.t      = t_q;
  assign beat_o.lim    = lim_q;
  assign beat_o.c0     = rd0_q;
  assign beat_o.c1     = rd1_q;

endmodule

FILE: sv/kcf_interp.sv
// Linear interpolation between two cells, divided by the axis step (three stages).
`timescale 1ns / 1ps

module kcf_interp import kcf_pkg::*; #(
  parameter int AXIS_STEP = 500
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  fetch_beat_t  beat_i,
  output logic         valid_o,
  input  logic         ready_i,
  output interp_beat_t beat_o
);

  localparam int F_W     = $clog2(AXIS_STEP + 1);
  localparam int S_W     = CELL_W + F_W;
  localparam int Q_SHIFT = 28;
  localparam int RQ_W    = Q_SHIFT + 1;
  localparam int QP_W    = S_W + RQ_W;
  localparam int N_W     = S_W + 8;
  localparam logic [RQ_W-1:0] RECIP_Q = RQ_W'(2**Q_SHIFT / AXIS_STEP);

  // Stage 4: weighted cell sum S = c0*step + (c1-c0)*frac
  logic             s4_v_q;
  logic             s4_active_q;
  logic [T_W-1:0]   s4_t_q;
  logic [LIM_W-1:0] s4_lim_q;
  logic [S_W-1:0]   s4_s_q;
  // Stage 5: quotient estimate
  logic             s5_v_q;
  logic             s5_active_q;
  logic [T_W-1:0]   s5_t_q;
  logic [LIM_W-1:0] s5_lim_q;
  logic [S_W-1:0]   s5_s_q;
  logic [MV_W-1:0]  s5_q_q;
  // Stage 6: corrected map value
  logic             s6_v_q;
  interp_beat_t     s6_q;

  logic s4_ready;
  logic s5_ready;
  logic s6_ready;

  logic [F_W-1:0]          frac;
  logic signed [CELL_W:0]  delta;
  logic signed [S_W:0]     dprod;
  logic [S_W:0]            base;
  logic signed [S_W:0]     ssum;
  logic [QP_W-1:0]         qprod;
  logic [N_W-1:0]          num;
  logic [N_W-1:0]          qstep;
  logic [N_W-1:0]          rem;

  assign s6_ready = !s6_v_q || ready_i;
  assign s5_ready = !s5_v_q || s6_ready;
  assign s4_ready = !s4_v_q || s5_ready;
  assign ready_o  = s4_ready;
  assign valid_o  = s6_v_q;
  assign beat_o   = s6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else begin
      if (s4_ready) s4_v_q <= valid_i;
      if (s5_ready) s5_v_q <= s4_v_q;
      if (s6_ready) s6_v_q <= s5_v_q;
    end
  end

  // Weighted sum
  assign frac  = beat_i.frac[F_W-1:0];
  assign delta = $signed({1'b0, beat_i.c1}) - $signed({1'b0, beat_i.c0});
  assign dprod = (S_W+1)'(delta) * (S_W+1)'($signed({1'b0, frac}));
  assign base  = (S_W+1)'(beat_i.c0) * (S_W+1)'(AXIS_STEP);
  assign ssum  = $signed(base) + dprod;

  always_ff @(posedge clk_i) begin
    if (s4_ready && valid_i) begin
      s4_active_q <= beat_i.active;
      s4_t_q      <= beat_i.t;
      s4_lim_q    <= beat_i.lim;
      s4_s_q      <= ssum[S_W-1:0];
    end
  end

  // Quotient estimate of 256*S / step, low by at most one
  assign qprod = QP_W'(s4_s_q) * QP_W'(RECIP_Q);

  always_ff @(posedge clk_i) begin
    if (s5_ready && s4_v_q) begin
      s5_active_q <= s4_active_q;
      s5_t_q      <= s4_t_q;
      s5_lim_q    <= s4_lim_q;
      s5_s_q      <= s4_s_q;
      s5_q_q      <= qprod[(Q_SHIFT-8) +: MV_W];
    end
  end

  // Remainder check and correction
  assign num   = {s5_s_q, 8'b0};
  assign qstep = N_W'(s5_q_q) * N_W'(AXIS_STEP);
  assign rem   = num - qstep;

  always_ff @(posedge clk_i) begin
    if (s6_ready && s5_v_q) begin
      s6_q.active <= s5_active_q;
      s6_q.t      <= s5_t_q;
      s6_q.lim    <= s5_lim_q;
      s6_q.mv     <= (rem >= N_W'(AXIS_STEP)) ? s5_q_q + 1'b1 : s5_q_q;
    end
  end

endmodule

FILE: sv/knock_correction_factor.sv
// Top level of the knock correction pipeline: registers, stages, output beat.
`timescale 1ns / 1ps

// Knock correction factor.
// in_i takes one beat per cycle while in_i.ready is high: a compute item
// (operation 0) or a load item (operation 1) that writes one cell of the rpm
// map. Each compute beat gives one beat on out_o; a load beat gives none. A
// cell must be loaded before a compute reads it.
// A compute result passes seven register stages, with one two-port read of
// the cell memory in the third stage, before it is presented on out_o.
// Throughput: one item per cycle while out_o does not stall.
// Loads and computes pass through the memory stage in order, so a compute
// sees every load accepted before it.
// The user writes the registers through cfg_we_i/cfg_idx_i/cfg_wdata_i only
// while no item is in flight; the block itself does not enforce this.
// Reset clears the pipeline and loads the register defaults; map cells keep
// no reset value. When out_o stalls, each stage holds its beat and in_i keeps
// accepting until the stages behind the output are full.
module knock_correction_factor import kcf_pkg::*; #(
  parameter int MAP_POINTS = 11,
  parameter int AXIS_STEP  = 500
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  kcf_in_if.sink                in_i,
  kcf_out_if.source             out_o
);

  cfg_t         cfg_q;

  logic         split_valid;
  logic         split_ready;
  split_beat_t  split_beat;
  logic         fetch_valid;
  logic         fetch_ready;
  fetch_beat_t  fetch_beat;
  logic         interp_valid;
  logic         interp_ready;
  interp_beat_t interp_beat;

  logic              out_v_q;
  logic [CORR_W-1:0] corr_q;
  logic              active_q;
  logic [LIM_W-1:0]  mlim;
  logic [LIM_W+T_W-1:0] prod;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.knock_threshold <= KNOCK_THRESHOLD_RST;
      cfg_q.temp_base       <= TEMP_BASE_RST;
      cfg_q.temp_gain       <= TEMP_GAIN_RST;
      cfg_q.axis_start      <= AXIS_START_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_KNOCK_THRESHOLD: cfg_q.knock_threshold <= cfg_wdata_i[7:0];
        REG_TEMP_BASE:       cfg_q.temp_base       <= cfg_wdata_i[TEMP_W-1:0];
        REG_TEMP_GAIN:       cfg_q.temp_gain       <= cfg_wdata_i[15:0];
        REG_AXIS_START:      cfg_q.axis_start      <= cfg_wdata_i[RPM_W-1:0];
        default: ;
      endcase
    end
  end

  kcf_split #(
    .MAP_POINTS (MAP_POINTS),
    .AXIS_STEP  (AXIS_STEP)
  ) u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_i    (in_i),
    .valid_o (split_valid),
    .ready_i (split_ready),
    .beat_o  (split_beat)
  );

  kcf_fetch #(
    .MAP_POINTS (MAP_POINTS),
    .AXIS_STEP  (AXIS_STEP)
  ) u_fetch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .beat_i  (split_beat),
    .valid_o (fetch_valid),
    .ready_i (fetch_ready),
    .beat_o  (fetch_beat)
  );

  kcf_interp #(
    .AXIS_STEP (AXIS_STEP)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fetch_valid),
    .ready_o (fetch_ready),
    .beat_i  (fetch_beat),
    .valid_o (interp_valid),
    .ready_i (interp_ready),
    .beat_o  (interp_beat)
  );

  // Output stage: limit, scale by temperature term, gate
  assign interp_ready = !out_v_q || out_o.ready;
  assign mlim = (interp_beat.lim < interp_beat.mv) ? interp_beat.lim : interp_beat.mv;
  assign prod = (LIM_W+T_W)'(mlim) * (LIM_W+T_W)'(interp_beat.t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (interp_ready) begin
      out_v_q <= interp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (interp_ready && interp_valid) begin
      corr_q   <= interp_beat.active ? prod[16 +: CORR_W] : '0;
      active_q <= interp_beat.active;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.correction = corr_q;
  assign out_o.active     = active_q;

endmodule

FILE: tb/sv/tb_knock_correction_factor.sv
// Self-checking testbench of the knock correction pipeline.
`timescale 1ns / 1ps

module tb_knock_correction_factor;
  import kcf_pkg::*;

  localparam int MAP_LEN       = 11;
  localparam int STEP_RPM      = 500;
  localparam int SETTLE_CYCLES = 16;    // pipeline depth plus margin
  localparam int LONG_HOLD     = 80;    // receiver hold-off that fills the stages
  localparam int STALL_LIMIT   = 2000;  // cycles without any beat before giving up

  // One input beat as the testbench sees it
  typedef struct {
    op_e                      op;
    logic [7:0]               enable_byte;
    logic [7:0]               knock_byte;
    logic signed [TEMP_W-1:0] coolant_temp;
    logic [RPM_W-1:0]         engine_rpm;
    logic [LIM_W-1:0]         correction_limit;
    logic [IDX_W-1:0]         cell_index;
    logic [CELL_W-1:0]        cell_value;
  } knock_req_t;

  // One result beat
  typedef struct {
    logic [CORR_W-1:0] correction;
    logic              active;
  } corr_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  kcf_in_if  in_ch ();
  kcf_out_if out_ch ();

  knock_correction_factor #(
    .MAP_POINTS(MAP_LEN),
    .AXIS_STEP (STEP_RPM)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the block state and the corrections still owed
  cfg_t              cfg_shadow;
  logic [CELL_W-1:0] map_shadow [MAP_LEN];
  corr_beat_t        pending_corrections [$];
  logic [CELL_W-1:0] seed_cells [MAP_LEN] = '{8'd255, 8'd0, 8'd37, 8'd200, 8'd91, 8'd255,
                                             8'd1, 8'd128, 8'd64, 8'd170, 8'd85};

  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;
  bit          src_gaps = 1'b1;
  bit          snk_gaps = 1'b1;
  bit          hold_request = 1'b0;

  // ---------------------------------------------------------------------------
  // Correction predictor
  // ---------------------------------------------------------------------------

  // Temperature term in Q1.16, clamped to [0, 1.0]
  function automatic longint temp_scale(logic signed [TEMP_W-1:0] temp);
    longint d;
    longint p;
    d = longint'(temp) - longint'($signed(cfg_shadow.temp_base));
    if (d <= 0) return 0;
    p = (d * longint'(cfg_shadow.temp_gain)) >> TEMP_FRAC;
    return (p > longint'(T_ONE)) ? longint'(T_ONE) : p;
  endfunction

  // Interpolated map value in 1/256 units (cell*256)
  function automatic longint map_level(logic [RPM_W-1:0] rpm);
    longint span;
    longint off;
    longint seg;
    longint frac;
    span = longint'((MAP_LEN - 1) * STEP_RPM);
    if (rpm <= cfg_shadow.axis_start) return longint'(map_shadow[0]) * 256;
    off = longint'(rpm) - longint'(cfg_shadow.axis_start);
    if (off >= span) return longint'(map_shadow[MAP_LEN-1]) * 256;
    seg  = off / STEP_RPM;
    frac = off % STEP_RPM;
    return (longint'(map_shadow[seg]) * 256 * (STEP_RPM - frac)
          + longint'(map_shadow[seg+1]) * 256 * frac) / STEP_RPM;
  endfunction

  function automatic corr_beat_t predict_correction(knock_req_t r);
    corr_beat_t b;
    longint     t;
    longint     mv;
    longint     m;
    b.correction = '0;
    b.active     = 1'b0;
    if (r.enable_byte == 8'd1 && r.knock_byte > cfg_shadow.knock_threshold) begin
      t  = temp_scale(r.coolant_temp);
      mv = map_level(r.engine_rpm);
      m  = (longint'(r.correction_limit) < mv) ? longint'(r.correction_limit) : mv;
      b.correction = CORR_W'((m * t) >> 16);
      b.active     = 1'b1;
    end
    return b;
  endfunction

  // Apply an accepted beat to the shadow state
  function automatic void absorb_req(knock_req_t r);
    if (r.op == OP_LOAD) begin
      if (r.cell_index < MAP_LEN) map_shadow[r.cell_index] = r.cell_value;
    end else begin
      pending_corrections.push_back(predict_correction(r));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic knock_req_t compute_req(logic [7:0] en, logic [7:0] kn,
                                             logic signed [TEMP_W-1:0] temp,
                                             logic [RPM_W-1:0] rpm, logic [LIM_W-1:0] lim);
    knock_req_t r;
    r.op               = OP_COMPUTE;
    r.enable_byte      = en;
    r.knock_byte       = kn;
    r.coolant_temp     = temp;
    r.engine_rpm       = rpm;
    r.correction_limit = lim;
    r.cell_index       = IDX_W'($urandom);
    r.cell_value       = CELL_W'($urandom);
    return r;
  endfunction

  function automatic knock_req_t load_req(logic [IDX_W-1:0] idx, logic [CELL_W-1:0] val);
    knock_req_t r;
    r = compute_req(8'($urandom), 8'($urandom), TEMP_W'($urandom), RPM_W'($urandom),
                    LIM_W'($urandom));
    r.op         = OP_LOAD;
    r.cell_index = idx;
    r.cell_value = val;
    return r;
  endfunction

  // Mostly gated-on computes near the active ranges, some loads and noise
  function automatic knock_req_t random_req();
    knock_req_t r;
    int         base;
    base = int'($signed(cfg_shadow.temp_base));
    if ($urandom_range(0, 9) < 2) return load_req(IDX_W'($urandom_range(0, 15)),
                                                  CELL_W'($urandom));
    r = compute_req(8'd1, 8'($urandom), TEMP_W'($urandom), RPM_W'($urandom),
                    LIM_W'($urandom));
    if ($urandom_range(0, 4) == 0) r.enable_byte = 8'($urandom);
    if ($urandom_range(0, 4) != 0 && cfg_shadow.knock_threshold != 8'hFF)
      r.knock_byte = 8'($urandom_range(int'(cfg_shadow.knock_threshold) + 1, 255));
    case ($urandom_range(0, 2))
      0: r.coolant_temp = TEMP_W'(base + int'($urandom_range(0, 8500)) - 500);
      1: r.coolant_temp = TEMP_W'(base + int'($urandom_range(0, 64)));
      default: ;
    endcase
    if ($urandom_range(0, 4) != 0)
      r.engine_rpm = RPM_W'(int'(cfg_shadow.axis_start) + int'($urandom_range(0, 5100)) - 50);
    case ($urandom_range(0, 3))
      0: r.correction_limit = 16'hFFFF;
      1: r.correction_limit = LIM_W'($urandom_range(0, 4096));
      default: ;
    endcase
    return r;
  endfunction

  function automatic cfg_t pack_cfg(logic [7:0] thr, logic [TEMP_W-1:0] base,
                                    logic [15:0] gain, logic [RPM_W-1:0] axis);
    cfg_t c;
    c.knock_threshold = thr;
    c.temp_base       = base;
    c.temp_gain       = gain;
    c.axis_start      = axis;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one beat, optionally after an idle burst, and wait until it is taken
  task automatic send_item(input knock_req_t r);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.operation        <= r.op;
    in_ch.enable_byte      <= r.enable_byte;
    in_ch.knock_byte       <= r.knock_byte;
    in_ch.coolant_temp     <= r.coolant_temp;
    in_ch.engine_rpm       <= r.engine_rpm;
    in_ch.correction_limit <= r.correction_limit;
    in_ch.cell_index       <= r.cell_index;
    in_ch.cell_value       <= r.cell_value;
    do @(posedge clk_i); while (!in_ch.ready);
    absorb_req(r);
  endtask

  // Stop offering and wait until the pipeline is empty, loads included
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Write all four registers; only called with the pipeline empty
  task automatic apply_settings(input cfg_t c);
    put_reg(REG_KNOCK_THRESHOLD, CFG_DATA_W'(c.knock_threshold));
    put_reg(REG_TEMP_BASE, c.temp_base);
    put_reg(REG_TEMP_GAIN, c.temp_gain);
    put_reg(REG_AXIS_START, CFG_DATA_W'(c.axis_start));
    cfg_we_i   <= 1'b0;
    cfg_shadow = c;
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_item(random_req());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill the map, then out-of-map loads, gate cases, axis edges, temperature extremes and limits
  task automatic test_directed();
    for (int k = 0; k < MAP_LEN; k++) send_item(load_req(IDX_W'(k), seed_cells[k]));
    // loads outside the map are dropped
    send_item(load_req(4'd11, 8'd0));
    send_item(load_req(4'd15, 8'd0));
    // gate off
    send_item(compute_req(8'd0, 8'd200, 16'sd1000, 14'd1000, 16'hFFFF));
    send_item(compute_req(8'd2, 8'd200, 16'sd1000, 14'd1000, 16'hFFFF));
    send_item(compute_req(8'd255, 8'd255, 16'sd1000, 14'd1000, 16'hFFFF));
    send_item(compute_req(8'd1, 8'd1, 16'sd1000, 14'd1000, 16'hFFFF));
    send_item(compute_req(8'd1, 8'd0, 16'sd1000, 14'd1000, 16'hFFFF));
    // knock just above threshold, on a map point
    send_item(compute_req(8'd1, 8'd2, 16'sd0, 14'd1000, 16'hFFFF));
    // below the axis (temperature term saturated), at the axis start and within the first step
    send_item(compute_req(8'd1, 8'd255, 16'sd32767, 14'd0, 16'hFFFF));
    send_item(compute_req(8'd1, 8'd100, 16'sd640, 14'd500, 16'hFFFF));
    send_item(compute_req(8'd1, 8'd100, 16'sd640, 14'd750, 16'hFFFF));
    // last step, last point, beyond the axis
    send_item(compute_req(8'd1, 8'd100, 16'sd6400, 14'd5499, 16'hFFFF));
    send_item(compute_req(8'd1, 8'd100, 16'sd6400, 14'd5500, 16'hFFFF));
    send_item(compute_req(8'd1, 8'd100, 16'sd6400, 14'd16383, 16'hFFFF));
    // temperature below, at and just above the base
    send_item(compute_req(8'd1, 8'd100, 16'sh8000, 14'd2000, 16'hFFFF));
    send_item(compute_req(8'd1, 8'd100, -16'sd1920, 14'd2000, 16'hFFFF));
    send_item(compute_req(8'd1, 8'd100, -16'sd1919, 14'd2000, 16'hFFFF));
    // limit zero and limit below the map value
    send_item(compute_req(8'd1, 8'd100, 16'sd32767, 14'd2000, 16'd0));
    send_item(compute_req(8'd1, 8'd100, 16'sd32767, 14'd2000, 16'd1000));
    settle();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_input_stall();
    src_gaps     = 1'b0;
    hold_request = 1'b1;
    send_random(40);
    src_gaps = 1'b1;
    settle();
  endtask

  // Both register extremes, every register written
  task automatic test_register_extremes();
    apply_settings(pack_cfg(8'd0, 16'h8000, 16'hFFFF, 14'd0));
    send_random(120);
    settle();
    apply_settings(pack_cfg(8'hFF, 16'h7FFF, 16'd0, 14'h3FFF));
    send_random(60);
    settle();
  endtask

  task automatic test_random_settings();
    apply_settings(pack_cfg(8'($urandom), TEMP_W'($urandom), 16'($urandom),
                            RPM_W'($urandom_range(0, 11000))));
    send_random(120);
    settle();
  endtask

  // Long stream at the reset values, written back explicitly
  task automatic test_random_stream();
    apply_settings(pack_cfg(KNOCK_THRESHOLD_RST, TEMP_BASE_RST, TEMP_GAIN_RST,
                            AXIS_START_RST));
    send_random(900);
    settle();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_steady_flow();
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    apply_settings(pack_cfg(8'($urandom_range(0, 64)), TEMP_W'($urandom_range(0, 4000)),
                            16'($urandom_range(100, 2000)), RPM_W'($urandom_range(0, 1500))));
    send_random(150);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= REG_KNOCK_THRESHOLD;
    cfg_wdata_i            <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.operation        <= OP_COMPUTE;
    in_ch.enable_byte      <= '0;
    in_ch.knock_byte       <= '0;
    in_ch.coolant_temp     <= '0;
    in_ch.engine_rpm       <= '0;
    in_ch.correction_limit <= '0;
    in_ch.cell_index       <= '0;
    in_ch.cell_value       <= '0;
    cfg_shadow = pack_cfg(KNOCK_THRESHOLD_RST, TEMP_BASE_RST, TEMP_GAIN_RST, AXIS_START_RST);
    foreach (map_shadow[k]) map_shadow[k] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_input_stall();
    test_register_extremes();
    test_random_settings();
    test_random_stream();
    test_steady_flow();

    in_ch.valid <= 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("knock_correction_factor verification clean");
    end else begin
      $display("knock_correction_factor verification failed");
    end
    $finish;
  end

  // Result side ready: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (snk_gaps && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    corr_beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_corrections.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result beat, correction %0d active %0b",
                 $time, out_ch.correction, out_ch.active);
      end else begin
        want = pending_corrections.pop_front();
        if (out_ch.correction !== want.correction) begin
          fault_count++;
          $display("%0t: correction mismatch, expected %0d actual %0d",
                   $time, want.correction, out_ch.correction);
        end
        if (out_ch.active !== want.active) begin
          fault_count++;
          $display("%0t: active mismatch, expected %0b actual %0b",
                   $time, want.active, out_ch.active);
        end
      end
    end
  end

  // Watchdog on cycles without any beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_corrections.size());
        $display("knock_correction_factor verification failed");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
sv/kcf_pkg.sv
sv/kcf_in_if.sv
sv/kcf_out_if.sv
sv/kcf_split.sv
sv/kcf_fetch.sv
sv/kcf_interp.sv
sv/knock_correction_factor.sv
tb/sv/tb_knock_correction_factor.sv
